// ===== sv/array_priority_queue_assert.svh =====
// Assertion macros for the array priority queue
`ifndef ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define APQ_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("array_priority_queue check failed");

// next-cycle implication, checked out of reset
`define APQ_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("array_priority_queue check failed");

`endif

// ===== sv/apq_pkg.sv =====
// Package with shared types and constants for the array priority queue
`timescale 1ns / 1ps

package apq_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int FIELD_W          = 16;
  localparam int ENTRY_W          = 2 * FIELD_W;
  localparam int KIND_W           = 2;
  localparam int STATUS_W         = 2;
  localparam int OCC_W            = 7;
  localparam int IN_DATA_W        = 32;
  localparam int OUT_DATA_W       = 40;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/array_priority_queue.sv =====
// Top level of the array priority queue: control, scan, shift and result register
//
// Input channel s_*: one item per handshake, tuser carries the kind (insert,
// remove best, peek best), tdata the length and priority to insert.
// Output channel m_*: exactly one item per input item, in order; tuser carries
// the status, tdata the best entry and the occupancy after the item.
// Entries sit unsorted, in insertion order, in one RAM of CAPACITY words.
// Insert, unused kind, insert when full, peek/remove when empty: the block goes
// straight from acceptance to its emit step, then back to idle for the next item.
// Peek: one RAM read per stored entry, then the emit step.
// Remove: the peek scan, then one read and one write per entry behind the best
// one to close the gap, then the emit step.
// The RAM read port, one word a cycle, paces the scan and the shift.
// s_tready is high while no item is in progress; a finished result waits in
// the output register, so the next item may be taken while m_tready is low.
// A result that cannot leave holds the block in its emit step.
// Reset empties the queue at once; RAM contents need no clearing.
`timescale 1ns / 1ps
`include "array_priority_queue_assert.svh"

module array_priority_queue #(
  parameter int CAPACITY = apq_pkg::CAPACITY_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] item_length, [31:16] item_priority
  input  logic [apq_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] kind
  input  logic [apq_pkg::KIND_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] best_length, [31:16] best_priority, [38:32] occupancy, [39] zero
  output logic [apq_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [1:0] status
  output logic [apq_pkg::STATUS_W-1:0]    m_tuser
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = apq_pkg::FIELD_W;
  localparam int EW = apq_pkg::ENTRY_W;

  apq_pkg::state_t state, state_next;

  logic [CW-1:0]               count;
  logic [CW-1:0]               ptr;
  logic                        rd_valid;
  logic [IW-1:0]               rd_idx;
  logic [EW-1:0]               rd_data;
  logic [EW-1:0]               best;
  logic [IW-1:0]               best_idx;
  logic                        is_remove;
  logic [FW-1:0]               res_len;
  logic [FW-1:0]               res_prio;
  logic [apq_pkg::STATUS_W-1:0] res_status;

  logic                        accept;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [EW-1:0]               wr_data;
  logic                        load_out;
  logic                        take;
  logic                        better;
  logic                        scan_last;
  logic                        full;
  logic [EW-1:0]               best_sel;
  logic [IW-1:0]               best_idx_sel;

  apq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == apq_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count >= CW'(CAPACITY));

  assign better = ($signed(rd_data[EW-1:FW]) > $signed(best[EW-1:FW])) ||
                  ((rd_data[EW-1:FW] == best[EW-1:FW]) && (rd_data[FW-1:0] < best[FW-1:0]));
  assign take         = (rd_idx == '0) || better;
  assign best_sel     = take ? rd_data : best;
  assign best_idx_sel = take ? rd_idx : best_idx;
  assign scan_last    = rd_valid && (CW'(rd_idx) == count - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = ptr[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = count[IW-1:0];
    wr_data    = s_tdata[EW-1:0];
    load_out   = 1'b0;
    unique case (state)
      apq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = apq_pkg::ST_EMIT;
          case (s_tuser) inside
            apq_pkg::KIND_INSERT: wr_en = !full;
            apq_pkg::KIND_REMOVE, apq_pkg::KIND_PEEK: begin
              if (count != '0) begin
                state_next = apq_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      apq_pkg::ST_SCAN: begin
        rd_en = (ptr < count);
        if (scan_last) begin
          state_next = is_remove ? apq_pkg::ST_SHIFT : apq_pkg::ST_EMIT;
        end
      end
      apq_pkg::ST_SHIFT: begin
        rd_en   = (ptr < count);
        wr_en   = rd_valid;
        wr_addr = rd_idx - IW'(1);
        wr_data = rd_data;
        if (!rd_en && !rd_valid) begin
          state_next = apq_pkg::ST_EMIT;
        end
      end
      apq_pkg::ST_EMIT: begin
        load_out = !m_tvalid || m_tready;
        if (load_out) begin
          state_next = apq_pkg::ST_IDLE;
        end
      end
      default: state_next = apq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (state == apq_pkg::ST_IDLE && accept && s_tuser == apq_pkg::KIND_INSERT && !full) begin
        count <= count + CW'(1);
      end
      if (state == apq_pkg::ST_SHIFT && state_next == apq_pkg::ST_EMIT) begin
        count <= count - CW'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    if (rd_en) begin
      ptr <= ptr + CW'(1);
    end
    unique case (state)
      apq_pkg::ST_IDLE: begin
        ptr        <= '0;
        is_remove  <= (s_tuser == apq_pkg::KIND_REMOVE);
        res_len    <= '0;
        res_prio   <= '0;
        res_status <= apq_pkg::STATUS_OK;
        case (s_tuser) inside
          apq_pkg::KIND_INSERT: begin
            if (full) begin
              res_status <= apq_pkg::STATUS_FULL;
            end
          end
          apq_pkg::KIND_REMOVE, apq_pkg::KIND_PEEK: begin
            if (count == '0) begin
              res_status <= apq_pkg::STATUS_EMPTY;
            end
          end
          default: ;
        endcase
      end
      apq_pkg::ST_SCAN: begin
        if (rd_valid) begin
          best     <= best_sel;
          best_idx <= best_idx_sel;
        end
        if (scan_last) begin
          res_len  <= best_sel[FW-1:0];
          res_prio <= best_sel[EW-1:FW];
          ptr      <= CW'(best_idx_sel) + CW'(1);
        end
      end
      default: ;
    endcase
    if (load_out) begin
      m_tdata <= {{(apq_pkg::OUT_DATA_W - EW - apq_pkg::OCC_W){1'b0}},
                  apq_pkg::OCC_W'(count), res_prio, res_len};
      m_tuser <= res_status;
    end
  end

  `APQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `APQ_ASSERT_NOW(a_write_phase, clk, rst, wr_en, state == apq_pkg::ST_IDLE || state == apq_pkg::ST_SHIFT)
  `APQ_ASSERT_NOW(a_read_in_range, clk, rst, rd_en, CW'(rd_addr) < count)
  `APQ_ASSERT_NEXT(a_emit_done, clk, rst, load_out, m_tvalid && state == apq_pkg::ST_IDLE)

endmodule

// ===== sv/apq_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module apq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
